@@ rtl/reed_solomon_parity_encoder_assert.svh @@
// ---------------------------------------------------------------------------
// reed_solomon_parity_encoder assertion macros
// shared property wrappers for the parity encoder checks
// ---------------------------------------------------------------------------
`ifndef REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH

// same-cycle implication
`define RSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rsp_pkg.sv @@
// ---------------------------------------------------------------------------
// rsp_pkg
// shared constants, types and gf(256) arithmetic for the parity encoder
// ---------------------------------------------------------------------------
package rsp_pkg;

  localparam int          DefMaxParity = 30;
  localparam int          EcCountW     = 5;
  localparam int          IdxW         = 5;
  localparam logic [4:0]  EcCountReset = 5'd10;
  // low byte of the field polynomial 0x11d
  localparam logic [7:0]  GfPolyLow    = 8'h1D;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // carry-less multiply with reduction, one bit of b per step
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GfPolyLow : 8'h00);
    end
    return p;
  endfunction

endpackage

@@ rtl/rsp_front.sv @@
// ---------------------------------------------------------------------------
// rsp_front
// config register and byte-wide remainder division, hands finished blocks on
// ---------------------------------------------------------------------------
module rsp_front import rsp_pkg::*; #(
  parameter int MaxParity = DefMaxParity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         ec_count_we_i,
  input  logic [EcCountW-1:0]          ec_count_i,
  input  logic                         push_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_data_i,
  input  q_stat_t                      q_stat_i,
  output logic                         q_push_o,
  output logic [MaxParity-1:0][7:0]    q_data_o,
  output logic [$clog2(MaxParity+1)-1:0] deg_o
);

  localparam int DegW     = $clog2(MaxParity + 1);
  localparam int DegReset = (int'(EcCountReset) > MaxParity) ? MaxParity : int'(EcCountReset);

  typedef logic [MaxParity:0][MaxParity:0][7:0] gen_tab_t;

  // generator coefficients per degree, leading term at index 0
  function automatic gen_tab_t build_gen();
    gen_tab_t   t;
    logic [7:0] root;
    t       = '0;
    t[0][0] = 8'h01;
    root    = 8'h01;
    for (int d = 1; d <= MaxParity; d++) begin
      t[d][0] = 8'h01;
      for (int k = 1; k <= d; k++) begin
        t[d][k] = t[d-1][k] ^ gf_mul(t[d-1][k-1], root);
      end
      root = gf_mul(root, 8'h02);
    end
    return t;
  endfunction

  localparam gen_tab_t GenTab = build_gen();

  logic [DegW-1:0]               deg_q, deg_wr;
  logic [MaxParity-1:0][7:0]     rem_q, rem_step;
  logic [MaxParity:0][7:0]       rem_ext;
  logic [7:0]                    fb;
  logic                          accept;

  always_comb begin
    if (ec_count_i == '0) begin
      deg_wr = DegW'(1);
    end else if (int'(ec_count_i) > MaxParity) begin
      deg_wr = DegW'(MaxParity);
    end else begin
      deg_wr = DegW'(ec_count_i);
    end
  end

  assign accept  = push_i && !q_stat_i.full;
  assign fb      = data_byte_i ^ rem_q[0];
  assign rem_ext = {8'h00, rem_q};

  // one lfsr step: shift toward index 0 and add feedback times generator
  always_comb begin
    for (int k = 0; k < MaxParity; k++) begin
      if (k < int'(deg_q)) begin
        rem_step[k] = ((k + 1 < int'(deg_q)) ? rem_ext[k+1] : 8'h00)
                    ^ gf_mul(fb, GenTab[deg_q][k+1]);
      end else begin
        rem_step[k] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= DegW'(DegReset);
      rem_q <= '0;
    end else if (ec_count_we_i) begin
      deg_q <= deg_wr;
      rem_q <= '0;
    end else if (accept) begin
      rem_q <= last_data_i ? '0 : rem_step;
    end
  end

  assign q_push_o = accept && last_data_i;
  assign q_data_o = rem_step;
  assign deg_o    = deg_q;

endmodule

@@ rtl/rsp_queue.sv @@
// ---------------------------------------------------------------------------
// rsp_queue
// two-entry queue of finished parity blocks between front and back
// ---------------------------------------------------------------------------
module rsp_queue import rsp_pkg::*; #(
  parameter int MaxParity = DefMaxParity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [MaxParity-1:0][7:0] data_i,
  input  logic                      pop_i,
  output logic [MaxParity-1:0][7:0] data_o,
  output q_stat_t                   stat_o
);

  logic [MaxParity-1:0][7:0] entry_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                count_q;
  logic                      do_push, do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/rsp_back.sv @@
// ---------------------------------------------------------------------------
// rsp_back
// unloads one parity block byte by byte through the output register
// ---------------------------------------------------------------------------
module rsp_back import rsp_pkg::*; #(
  parameter int MaxParity = DefMaxParity
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(MaxParity+1)-1:0] deg_i,
  input  q_stat_t                        q_stat_i,
  input  logic [MaxParity-1:0][7:0]      q_data_i,
  output logic                           q_pop_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [7:0]                     parity_byte_o,
  output logic [IdxW-1:0]                parity_index_o,
  output logic                           last_parity_o
);

  localparam int DegW = $clog2(MaxParity + 1);

  logic [MaxParity-1:0][7:0] shift_q;
  logic [DegW-1:0]           idx_q;
  logic                      busy_q;
  logic                      last, take, load, step;

  assign last    = (idx_q == DegW'(deg_i - DegW'(1)));
  assign step    = pop_i && busy_q;
  assign take    = !busy_q || (step && last);
  assign load    = take && !q_stat_i.empty;
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (step) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + DegW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= q_data_i;
    end else if (step) begin
      shift_q <= {8'h00, shift_q[MaxParity-1:1]};
    end
  end

  assign empty_o        = !busy_q;
  assign parity_byte_o  = shift_q[0];
  assign parity_index_o = IdxW'(idx_q);
  assign last_parity_o  = last;

endmodule

@@ rtl/reed_solomon_parity_encoder.sv @@
// ---------------------------------------------------------------------------
// reed_solomon_parity_encoder
// qr-style reed-solomon parity generator over gf(256), polynomial 0x11d
// ---------------------------------------------------------------------------
// usage
//   input side is a queue: a data byte transfers when push_i is high and
//   full_o is low; last_data_i marks the final byte of a block
//   output side is a queue: while empty_o is low the oldest parity byte sits
//   on parity_byte_o / parity_index_o / last_parity_o and transfers on pop_i
//   ec_count_i is written with ec_count_we_i (only while idle); it sets the
//   parity count per block and clears the running remainder
// timing
//   one data byte per cycle while full_o is low (combinational lfsr step)
//   after the last data byte's transfer the block is queued, then loaded
//   to parity_byte_o; one parity byte per cycle while the receiver pops
//   up to two finished blocks wait in the queue; full_o rises once both
//   slots hold blocks, so a stalled receiver backs up into the input side
// reset
//   remainder cleared, ec_count back to 10, queue and output empty
// ---------------------------------------------------------------------------
module reed_solomon_parity_encoder import rsp_pkg::*; #(
  parameter int MaxParity = DefMaxParity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ec_count_we_i,
  input  logic [EcCountW-1:0] ec_count_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_data_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          parity_byte_o,
  output logic [IdxW-1:0]     parity_index_o,
  output logic                last_parity_o
);

`include "reed_solomon_parity_encoder_assert.svh"

  localparam int DegW = $clog2(MaxParity + 1);

  q_stat_t                   q_stat;
  logic                      q_push, q_pop;
  logic [MaxParity-1:0][7:0] q_wdata, q_rdata;
  logic [DegW-1:0]           deg;

  // front: config and division of the byte stream
  rsp_front #(.MaxParity(MaxParity)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ec_count_we_i (ec_count_we_i),
    .ec_count_i    (ec_count_i),
    .push_i        (push_i),
    .data_byte_i   (data_byte_i),
    .last_data_i   (last_data_i),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata),
    .deg_o         (deg)
  );

  // finished remainders wait here
  rsp_queue #(.MaxParity(MaxParity)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // back: byte-serial unload toward the receiver
  rsp_back #(.MaxParity(MaxParity)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deg_i          (deg),
    .q_stat_i       (q_stat),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .parity_byte_o  (parity_byte_o),
    .parity_index_o (parity_index_o),
    .last_parity_o  (last_parity_o)
  );

  // input stalls only when both queue slots are taken
  assign full_o = q_stat.full;

  // a block always starts at parity index zero
  `RSP_ASSERT_IMP(a_block_starts_at_zero, clk_i, rst_ni, $fell(empty_o),
                  parity_index_o == '0, "parity block did not start at index zero")

  // within a block the index advances by one per transfer
  `RSP_ASSERT_NXT(a_index_advances, clk_i, rst_ni, pop_i && !empty_o && !last_parity_o,
                  !empty_o && parity_index_o == IdxW'($past(parity_index_o) + IdxW'(1)),
                  "parity index did not advance by one")

  // final byte sits at the configured degree minus one
  `RSP_ASSERT_IMP(a_last_at_degree, clk_i, rst_ni, !empty_o && last_parity_o,
                  parity_index_o == IdxW'(deg - DegW'(1)),
                  "last parity byte at wrong index")

endmodule
